// ===== rtl/scsp_pkg.sv =====
// Shared types, codes and constants of the S-curve stepper profile block.
package scsp_pkg;

  localparam int STEP_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int ZONE_W = STEP_W + 10;

  localparam int DIV_W = 115;
  localparam int REM_W = 88;
  localparam int CNT_W = 7;
  localparam int ROOT_X_W = 96;
  localparam int ROOT_R_W = 72;

  localparam logic [CNT_W-1:0] TS_DIV_BITS = CNT_W'(DIV_W);
  localparam logic [CNT_W-1:0] PER_DIV_BITS = CNT_W'(36);
  localparam logic [CNT_W-1:0] ROOT_STEPS = CNT_W'(32);
  localparam logic [DIV_W-1:0] TS_DIVIDEND = DIV_W'(6) << 112;
  localparam logic [DIV_W-1:0] PER_DIVIDEND = DIV_W'(64'd1000000 << 16) << (DIV_W - 36);

  localparam logic [19:0] MICROS_PER_S = 20'd1000000;
  localparam logic [STEP_W-1:0] SHORT_MOVE_LIMIT = STEP_W'(2000);

  localparam logic [15:0] MIN_SPEED_RST = 16'd200;
  localparam logic [15:0] MAX_SPEED_RST = 16'd2000;
  localparam logic [23:0] MAX_JERK_RST = 24'd100000;
  localparam logic [23:0] MAX_ACCEL_RST = 24'd20000;
  localparam logic [15:0] RATIO_LONG_RST = 16'd13107;
  localparam logic [15:0] RATIO_SHORT_RST = 16'd26214;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SPEED   = 3'd0,
    REG_MAX_SPEED   = 3'd1,
    REG_MAX_JERK    = 3'd2,
    REG_MAX_ACCEL   = 3'd3,
    REG_RATIO_LONG  = 3'd4,
    REG_RATIO_SHORT = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_STEP    = 2'd0,
    ST_LOADED  = 2'd1,
    ST_NO_MOVE = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RAMP,
    OP_M1,
    OP_M2LO,
    OP_M2HI,
    OP_BASE,
    OP_DIV_TS,
    OP_DIV_STEP,
    OP_ROOT_INIT,
    OP_ROOT_MUL,
    OP_ROOT_CMP,
    OP_TS,
    OP_PER_START,
    OP_PERIOD,
    OP_ACC,
    OP_SPD_MUL,
    OP_SPD,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic                command;
    logic [STEP_W-1:0]   step_count;
    logic                forward;
  } item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [19:0]         period_us;
    logic signed [31:0]  position_now;
    logic                last_step;
  } result_t;

  typedef struct packed {
    op_t     op;
    status_t res;
  } dp_cmd_t;

  typedef struct packed {
    logic r8_zero;
    logic base_zero;
    logic cnt_last;
    logic active;
    logic zone_any;
  } dp_stat_t;

endpackage

// ===== rtl/scsp_datapath.sv =====
// Datapath: configuration, motion state, shared multiplier, divider and cube root.
module scsp_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  scsp_pkg::dp_cmd_t                 cmd,
  output scsp_pkg::dp_stat_t                stat,
  input  scsp_pkg::item_t                   item,
  output scsp_pkg::result_t                 result,
  input  logic                              cfg_we,
  input  logic [scsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scsp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [15:0] floor_speed, ceil_speed, ratio_long, ratio_short;
  logic [23:0] jerk_mag, max_accel;

  logic [31:0] position_count, speed_now, accel_now, tstep, ramp_length;
  logic [scsp_pkg::STEP_W-1:0] step_index, move_length;
  logic move_dir, move_active;

  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;
  logic        mul_en;
  logic [23:0] m1;
  logic [87:0] base;

  logic [scsp_pkg::DIV_W-1:0] dvd, quo;
  logic [scsp_pkg::REM_W-1:0] rem, dvs;
  logic [scsp_pkg::CNT_W-1:0] cnt;
  logic [scsp_pkg::REM_W:0]   rem_sh;
  logic                       div_ge;

  logic [scsp_pkg::ROOT_X_W-1:0] root_x;
  logic [scsp_pkg::ROOT_R_W-1:0] root_r, root_b;
  logic [31:0] root_y, root_y2;

  logic zone_up, zone_dn, jerk_pos, last_reg;
  logic [19:0] period_reg;

  logic [scsp_pkg::ZONE_W-1:0] i8, i9, n8, n9, r8w;
  logic up_zone, up_first, dn_zone, dn_first;
  logic [scsp_pkg::STEP_W:0] i_inc;

  logic [39:0] da;
  logic [40:0] acc_sum;
  logic [40:0] acc_ceil;
  logic [31:0] dv;
  logic [32:0] spd_sum;
  logic [31:0] spd_dn, vmin, vmax;
  logic [scsp_pkg::STEP_W-1:0] n_in;
  logic [15:0] ratio_sel;

  assign n_in = item.step_count;
  assign ratio_sel = (n_in < scsp_pkg::SHORT_MOVE_LIMIT) ? ratio_short : ratio_long;

  always_comb begin
    mul_en = 1'b1;
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      scsp_pkg::OP_LOAD: begin
        mul_a = 32'(n_in);
        mul_b = 32'(ratio_sel);
      end
      scsp_pkg::OP_M1: begin
        mul_a = 32'(jerk_mag);
        mul_b = ramp_length;
      end
      scsp_pkg::OP_M2LO: begin
        mul_a = prod[31:0];
        mul_b = ramp_length;
      end
      scsp_pkg::OP_M2HI: begin
        mul_a = 32'(m1);
        mul_b = ramp_length;
      end
      scsp_pkg::OP_ROOT_MUL: begin
        mul_a = root_y2;
        mul_b = root_y2 | 32'd1;
      end
      scsp_pkg::OP_PERIOD: begin
        mul_a = 32'(jerk_mag);
        mul_b = tstep;
      end
      scsp_pkg::OP_SPD_MUL: begin
        mul_a = accel_now;
        mul_b = tstep;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign root_y2 = {root_y[30:0], 1'b0};
  assign root_b = scsp_pkg::ROOT_R_W'({prod, 1'b0}) + scsp_pkg::ROOT_R_W'(prod) +
                  scsp_pkg::ROOT_R_W'(1);

  assign rem_sh = {rem, dvd[scsp_pkg::DIV_W-1]};
  assign div_ge = rem_sh >= {1'b0, dvs};

  assign i8 = scsp_pkg::ZONE_W'(step_index) << 8;
  assign i9 = scsp_pkg::ZONE_W'(step_index) << 9;
  assign n8 = scsp_pkg::ZONE_W'(move_length) << 8;
  assign n9 = scsp_pkg::ZONE_W'(move_length) << 9;
  assign r8w = scsp_pkg::ZONE_W'(ramp_length);
  assign up_zone = i8 < r8w;
  assign up_first = i9 < r8w;
  assign dn_zone = (i8 + r8w) >= n8;
  assign dn_first = (i9 + r8w) < n9;
  assign i_inc = {1'b0, step_index} + 1'b1;

  assign da = prod[55:16];
  assign acc_sum = 41'(accel_now) + 41'(da);
  assign acc_ceil = (max_accel[23:16] != 8'd0) ? 41'(32'hFFFF_FFFF) :
                    41'({max_accel[15:0], 16'd0});
  assign dv = prod[63:32];
  assign vmax = {ceil_speed, 16'd0};
  assign vmin = {floor_speed, 16'd0};
  assign spd_sum = {1'b0, speed_now} + {1'b0, dv};
  assign spd_dn = (dv > speed_now) ? 32'd0 : speed_now - dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_speed <= scsp_pkg::MIN_SPEED_RST;
      ceil_speed <= scsp_pkg::MAX_SPEED_RST;
      jerk_mag <= scsp_pkg::MAX_JERK_RST;
      max_accel <= scsp_pkg::MAX_ACCEL_RST;
      ratio_long <= scsp_pkg::RATIO_LONG_RST;
      ratio_short <= scsp_pkg::RATIO_SHORT_RST;
    end else if (cfg_we) begin
      case (scsp_pkg::reg_idx_t'(cfg_index))
        scsp_pkg::REG_MIN_SPEED: floor_speed <= cfg_data[15:0];
        scsp_pkg::REG_MAX_SPEED: ceil_speed <= cfg_data[15:0];
        scsp_pkg::REG_MAX_JERK: jerk_mag <= cfg_data;
        scsp_pkg::REG_MAX_ACCEL: max_accel <= cfg_data;
        scsp_pkg::REG_RATIO_LONG: ratio_long <= cfg_data[15:0];
        scsp_pkg::REG_RATIO_SHORT: ratio_short <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      speed_now <= '0;
      accel_now <= '0;
      tstep <= '0;
      ramp_length <= '0;
      step_index <= '0;
      move_length <= '0;
      move_dir <= 1'b0;
      move_active <= 1'b0;
    end else begin
      case (cmd.op)
        scsp_pkg::OP_LOAD: begin
          move_length <= n_in;
          move_dir <= item.forward;
          speed_now <= vmin;
          accel_now <= '0;
          step_index <= '0;
          move_active <= n_in != '0;
        end
        scsp_pkg::OP_RAMP: ramp_length <= prod[39:8];
        scsp_pkg::OP_TS: begin
          if (ramp_length == '0) begin
            tstep <= '0;
          end else if (base == '0) begin
            tstep <= '1;
          end else begin
            tstep <= root_y;
          end
        end
        scsp_pkg::OP_PER_START: begin
          position_count <= move_dir ? position_count + 32'd1 : position_count - 32'd1;
          step_index <= i_inc[scsp_pkg::STEP_W-1:0];
          if (i_inc >= {1'b0, move_length}) begin
            move_active <= 1'b0;
          end
        end
        scsp_pkg::OP_ACC: begin
          if (jerk_pos) begin
            accel_now <= (acc_sum > acc_ceil) ? acc_ceil[31:0] : acc_sum[31:0];
          end else begin
            accel_now <= (da > 40'(accel_now)) ? 32'd0 : accel_now - da[31:0];
          end
        end
        scsp_pkg::OP_SPD: begin
          if (zone_up) begin
            speed_now <= (spd_sum > {1'b0, vmax}) ? vmax : spd_sum[31:0];
          end else begin
            speed_now <= (spd_dn < vmin) ? vmin : spd_dn;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (cmd.op)
      scsp_pkg::OP_M2LO: m1 <= prod[55:32];
      scsp_pkg::OP_M2HI: base <= 88'(prod);
      scsp_pkg::OP_BASE: base <= base + (88'(prod) << 32);
      scsp_pkg::OP_DIV_TS: begin
        rem <= '0;
        dvd <= scsp_pkg::TS_DIVIDEND;
        dvs <= base;
        cnt <= scsp_pkg::TS_DIV_BITS;
      end
      scsp_pkg::OP_PER_START: begin
        rem <= '0;
        dvd <= scsp_pkg::PER_DIVIDEND;
        dvs <= scsp_pkg::REM_W'(speed_now);
        cnt <= scsp_pkg::PER_DIV_BITS;
        zone_up <= up_zone;
        zone_dn <= !up_zone && dn_zone;
        jerk_pos <= up_zone ? up_first : dn_first;
        last_reg <= i_inc >= {1'b0, move_length};
      end
      scsp_pkg::OP_DIV_STEP: begin
        rem <= div_ge ? rem_sh[scsp_pkg::REM_W-1:0] - dvs : rem_sh[scsp_pkg::REM_W-1:0];
        quo <= {quo[scsp_pkg::DIV_W-2:0], div_ge};
        dvd <= {dvd[scsp_pkg::DIV_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
      scsp_pkg::OP_ROOT_INIT: begin
        root_x <= (quo[scsp_pkg::DIV_W-1:scsp_pkg::ROOT_X_W] != '0) ? '1 :
                  quo[scsp_pkg::ROOT_X_W-1:0];
        root_r <= '0;
        root_y <= '0;
        cnt <= scsp_pkg::ROOT_STEPS;
      end
      scsp_pkg::OP_ROOT_MUL: begin
        root_r <= {root_r[scsp_pkg::ROOT_R_W-4:0],
                   root_x[scsp_pkg::ROOT_X_W-1:scsp_pkg::ROOT_X_W-3]};
        root_x <= {root_x[scsp_pkg::ROOT_X_W-4:0], 3'b000};
        root_y <= root_y2;
      end
      scsp_pkg::OP_ROOT_CMP: begin
        if (root_r >= root_b) begin
          root_r <= root_r - root_b;
          root_y <= root_y | 32'd1;
        end
        cnt <= cnt - 1'b1;
      end
      scsp_pkg::OP_PERIOD: begin
        period_reg <= (quo[35:0] > 36'(scsp_pkg::MICROS_PER_S)) ? scsp_pkg::MICROS_PER_S :
                      quo[19:0];
      end
      scsp_pkg::OP_OUT: begin
        result.status <= cmd.res;
        result.position_now <= position_count;
        result.period_us <= (cmd.res == scsp_pkg::ST_STEP) ? period_reg : 20'd0;
        result.last_step <= (cmd.res == scsp_pkg::ST_STEP) ? last_reg : 1'b0;
      end
      default: ;
    endcase
  end

  assign stat.r8_zero = ramp_length == '0;
  assign stat.base_zero = base == '0;
  assign stat.cnt_last = cnt == scsp_pkg::CNT_W'(1);
  assign stat.active = move_active;
  assign stat.zone_any = zone_up || zone_dn;

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    cmd.op == scsp_pkg::OP_DIV_STEP |-> cnt != '0)
    else $error("divider stepped past its last bit");
  a_speed_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.op == scsp_pkg::OP_SPD && zone_up |=> speed_now <= vmax)
    else $error("speed exceeds the ceiling after a ramp-up update");
  a_period_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.op == scsp_pkg::OP_PERIOD |=> period_reg <= scsp_pkg::MICROS_PER_S)
    else $error("period above one second");

endmodule

// ===== rtl/scsp_controller.sv =====
// Controller: sequences the datapath for move loads and step issues.
module scsp_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 item_command,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  scsp_pkg::dp_stat_t   stat,
  output scsp_pkg::dp_cmd_t    cmd
);

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_RAMP      = 17'h00002,
    S_M1        = 17'h00004,
    S_M2LO      = 17'h00008,
    S_M2HI      = 17'h00010,
    S_BASE      = 17'h00020,
    S_DIV_TS    = 17'h00040,
    S_DIV_STEP  = 17'h00080,
    S_ROOT_INIT = 17'h00100,
    S_ROOT_MUL  = 17'h00200,
    S_ROOT_CMP  = 17'h00400,
    S_TS        = 17'h00800,
    S_PER_DIV   = 17'h01000,
    S_PERIOD    = 17'h02000,
    S_ACC       = 17'h04000,
    S_SPD       = 17'h08000,
    S_DONE      = 17'h10000
  } state_t;

  state_t state, state_next;
  scsp_pkg::status_t res, res_next;
  logic spd_mul, spd_mul_next;
  logic accept;

  assign item_ready = state == S_IDLE;
  assign accept = item_valid && item_ready;

  always_comb begin
    state_next = state;
    res_next = res;
    spd_mul_next = spd_mul;
    cmd.op = scsp_pkg::OP_NONE;
    cmd.res = res;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (item_command == scsp_pkg::CMD_START) begin
            cmd.op = scsp_pkg::OP_LOAD;
            res_next = scsp_pkg::ST_LOADED;
            state_next = S_RAMP;
          end else if (stat.active) begin
            cmd.op = scsp_pkg::OP_PER_START;
            res_next = scsp_pkg::ST_STEP;
            state_next = S_PER_DIV;
          end else begin
            res_next = scsp_pkg::ST_NO_MOVE;
            state_next = S_DONE;
          end
        end
      end
      S_RAMP: begin
        cmd.op = scsp_pkg::OP_RAMP;
        state_next = S_M1;
      end
      S_M1: begin
        if (stat.r8_zero) begin
          state_next = S_TS;
        end else begin
          cmd.op = scsp_pkg::OP_M1;
          state_next = S_M2LO;
        end
      end
      S_M2LO: begin
        cmd.op = scsp_pkg::OP_M2LO;
        state_next = S_M2HI;
      end
      S_M2HI: begin
        cmd.op = scsp_pkg::OP_M2HI;
        state_next = S_BASE;
      end
      S_BASE: begin
        cmd.op = scsp_pkg::OP_BASE;
        state_next = S_DIV_TS;
      end
      S_DIV_TS: begin
        if (stat.base_zero) begin
          state_next = S_TS;
        end else begin
          cmd.op = scsp_pkg::OP_DIV_TS;
          state_next = S_DIV_STEP;
        end
      end
      S_DIV_STEP: begin
        cmd.op = scsp_pkg::OP_DIV_STEP;
        if (stat.cnt_last) begin
          state_next = S_ROOT_INIT;
        end
      end
      S_ROOT_INIT: begin
        cmd.op = scsp_pkg::OP_ROOT_INIT;
        state_next = S_ROOT_MUL;
      end
      S_ROOT_MUL: begin
        cmd.op = scsp_pkg::OP_ROOT_MUL;
        state_next = S_ROOT_CMP;
      end
      S_ROOT_CMP: begin
        cmd.op = scsp_pkg::OP_ROOT_CMP;
        state_next = stat.cnt_last ? S_TS : S_ROOT_MUL;
      end
      S_TS: begin
        cmd.op = scsp_pkg::OP_TS;
        state_next = S_DONE;
      end
      S_PER_DIV: begin
        cmd.op = scsp_pkg::OP_DIV_STEP;
        if (stat.cnt_last) begin
          state_next = S_PERIOD;
        end
      end
      S_PERIOD: begin
        cmd.op = scsp_pkg::OP_PERIOD;
        state_next = stat.zone_any ? S_ACC : S_DONE;
      end
      S_ACC: begin
        cmd.op = scsp_pkg::OP_ACC;
        spd_mul_next = 1'b1;
        state_next = S_SPD;
      end
      S_SPD: begin
        if (spd_mul) begin
          cmd.op = scsp_pkg::OP_SPD_MUL;
          spd_mul_next = 1'b0;
        end else begin
          cmd.op = scsp_pkg::OP_SPD;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.op = scsp_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res <= scsp_pkg::ST_NO_MOVE;
      spd_mul <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      res <= res_next;
      spd_mul <= spd_mul_next;
      if (cmd.op == scsp_pkg::OP_OUT) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item_ready)
    else $error("item taken while the previous one is still in work");
  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && result_valid && !result_ready |=> state == S_DONE)
    else $error("result slot overwritten while still occupied");
  a_out_sets_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && state_next == S_IDLE |=> result_valid && state == S_IDLE)
    else $error("finished item not presented");

endmodule

// ===== rtl/s_curve_stepper_profile.sv =====
// Top level of the jerk-limited S-curve stepper motion profile block.
// A start item keeps the block busy from its acceptance until the next item can be taken,
// while the bit-serial division and the cube root produce the time step; a move with a zero
// ramp skips the multiplies, the division and the root, and one with zero jerk skips the
// division and the root. A step item runs the bit-serial period division and then, in a ramp
// zone, the profile update; a step with no move active goes straight to the output. One item
// is in work at a time, and the next item is taken while a finished result waits in the output
// register; a result that is not taken holds the following one back.
module s_curve_stepper_profile (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  scsp_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output scsp_pkg::result_t                 result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scsp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  scsp_pkg::dp_cmd_t  cmd;
  scsp_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  scsp_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_command (item.command),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  scsp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item),
    .result    (result),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
